@@ hdl/first_fit_heap_allocator_core_defines.svh @@
// Assertion macros shared by the heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ffha_pkg.sv @@
// Package with types, codes and constants of the heap allocator.
package ffha_pkg;

   localparam int unsigned DefHeapBytes = 32768;
   localparam int unsigned OwnerBits    = 8;

   localparam logic [31:0] AllocBit = 32'h8000_0000;
   localparam logic [31:0] SizeMask = 32'h7FFF_FFFF;
   localparam logic [31:0] HdrBytes = 32'd8;
   localparam logic [31:0] StackTag = 32'hFFFF_FFFF;

   localparam logic [63:0] OwnerMaskWide = (64'd1 << OwnerBits) - 64'd1;
   localparam logic [31:0] OwnerMask     = OwnerMaskWide[31:0];

   localparam logic [1:0] ReqAlloc = 2'd0;
   localparam logic [1:0] ReqFree  = 2'd1;
   localparam logic [1:0] ReqCount = 2'd2;

   localparam logic [1:0] StsOk         = 2'd0;
   localparam logic [1:0] StsNoFit      = 2'd1;
   localparam logic [1:0] StsNotAlloc   = 2'd2;
   localparam logic [1:0] StsWrongOwner = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] req_size;
      logic [14:0] block_addr;
      logic [7:0]  owner_id;
      logic        stack_owner;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] payload_addr;
      logic [12:0] small_count;
   } rsp_word_type;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_DONE,
      S_AL_CHK, S_AL_RD0, S_AL_D0, S_AL_RD1, S_AL_D1, S_AL_WN0, S_AL_WN1,
      S_AL_LINK, S_AL_FIN, S_AL_WC0, S_AL_WC1,
      S_FR_RH, S_FR_DH, S_FR_RT, S_FR_DT, S_FR_WS, S_FR_WALK, S_FR_RW, S_FR_DW,
      S_FR_RL, S_FR_DL, S_FR_RR, S_FR_DR, S_FR_WL0, S_FR_WB0, S_FR_RR1, S_FR_DR1,
      S_FR_WL1, S_FR_WB1, S_FR_LINK,
      S_CN_CHK, S_CN_RD0, S_CN_D0, S_CN_RD1, S_CN_D1
   } state_type;

endpackage

@@ hdl/ffha_ram.sv @@
// Generic single-port RAM with registered read data.
module ffha_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/first_fit_heap_allocator_core.sv @@
// Top level of the first-fit heap allocator with an address-ordered free list.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  ffha_pkg::req_word_type
//   rsp      out        rsp_valid / rsp_ready  ffha_pkg::rsp_word_type
//
// One request is worked on at a time. Allocate and count make two reads of the header
// memory on each list node visited; free makes one read per node on its walk.
// After reset a clearing pass writes the header memory, during which no request is
// taken.
// A new request is taken while the previous response still waits on rsp_ready.
`include "first_fit_heap_allocator_core_defines.svh"

module first_fit_heap_allocator_core #(
   parameter int unsigned HEAP_BYTES = ffha_pkg::DefHeapBytes
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::rsp_word_type rsp_word
);

   localparam int unsigned HeapWords = HEAP_BYTES / 4;
   localparam int unsigned WordW     = $clog2(HeapWords);
   localparam int unsigned HeadW     = $clog2(HeapWords + 1);
   localparam int unsigned MaxWalk   = HEAP_BYTES / 8 + 2;
   localparam int unsigned StepW     = $clog2(MaxWalk + 1);

   localparam logic [31:0]       EndMark  = 32'(HEAP_BYTES);
   localparam logic [31:0]       WordsLim = 32'(HeapWords);
   localparam logic [StepW-1:0]  MaxSteps = StepW'(MaxWalk);
   localparam logic [WordW-1:0]  LastIdx  = WordW'(HeapWords - 1);
   localparam logic [HeadW-1:0]  HeadMax  = HeadW'(HeapWords);

   ffha_pkg::state_type    state_ff, state_in;
   logic [HeadW-1:0]       head_ff, head_in;
   logic [WordW-1:0]       clr_idx_ff, clr_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   ffha_pkg::req_word_type req_ff, req_in;
   logic [31:0]            tag_ff, tag_in;
   logic [31:0]            cur_ff, cur_in;
   logic [31:0]            prev_ff, prev_in;
   logic                   prev_head_ff, prev_head_in;
   logic [31:0]            blk_ff, blk_in;
   logic [31:0]            need_ff, need_in;
   logic [31:0]            csz_ff, csz_in;
   logic [31:0]            rsz_ff, rsz_in;
   logic [31:0]            link_ff, link_in;
   logic [StepW-1:0]       steps_ff, steps_in;
   logic [12:0]            count_ff, count_in;
   logic [1:0]             status_ff, status_in;
   logic [14:0]            payload_ff, payload_in;
   logic                   prev_t_ff, prev_t_in;
   logic                   next_t_ff, next_t_in;
   logic                   rd_ok_ff;

   logic [31:0]      acc_off, acc_idx, acc_wd;
   logic             acc_k, acc_we, acc_ok;
   logic             mem_we;
   logic [WordW-1:0] mem_addr;
   logic [31:0]      mem_wdata, mem_rdata, rdata;
   logic [31:0]      head_ptr, size32, need_calc, req_tag, clamp_src, clamp_val, clamp_sh;
   logic             walk_quiet, rsp_load;

   ffha_ram #(
      .WIDTH(32),
      .DEPTH(HeapWords)
   ) u_hdr_ram (
      .clock(clock),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   assign head_ptr  = 32'(head_ff) << 2;
   assign size32    = 32'(req_ff.req_size);
   assign need_calc = ((size32 > 32'd8) ? ((size32 + 32'd7) & ~32'd7) : 32'd8)
                      + ffha_pkg::HdrBytes;
   assign req_tag   = req_word.stack_owner ? ffha_pkg::StackTag
                      : (32'(req_word.owner_id) & ffha_pkg::OwnerMask);
   assign clamp_val = (clamp_src > EndMark) ? EndMark : clamp_src;
   assign clamp_sh  = clamp_val >> 2;

   assign acc_idx = (acc_off >> 2) + 32'(acc_k);
   assign acc_ok  = (acc_off < EndMark) && (acc_idx < WordsLim);
   assign rdata   = rd_ok_ff ? mem_rdata : 32'd0;

   always_comb begin
      if (state_ff == ffha_pkg::S_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_idx_ff;
         mem_wdata = (clr_idx_ff == '0) ? EndMark
                     : ((clr_idx_ff == WordW'(1)) ? EndMark : 32'd0);
      end else begin
         mem_we    = acc_we && acc_ok;
         mem_addr  = acc_idx[WordW-1:0];
         mem_wdata = acc_wd;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      req_in       = req_ff;
      tag_in       = tag_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_head_in = prev_head_ff;
      blk_in       = blk_ff;
      need_in      = need_ff;
      csz_in       = csz_ff;
      rsz_in       = rsz_ff;
      link_in      = link_ff;
      steps_in     = steps_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      payload_in   = payload_ff;
      prev_t_in    = prev_t_ff;
      next_t_in    = next_t_ff;
      acc_off      = cur_ff;
      acc_k        = 1'b0;
      acc_we       = 1'b0;
      acc_wd       = 32'd0;
      clamp_src    = link_ff;
      req_ready    = 1'b0;

      case (state_ff)
         ffha_pkg::S_CLEAR: begin
            clr_idx_in = clr_idx_ff + WordW'(1);
            if (clr_idx_ff == LastIdx) begin
               state_in = ffha_pkg::S_IDLE;
            end
         end
         ffha_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_word;
               tag_in   = req_tag;
               state_in = ffha_pkg::S_DECODE;
            end
         end
         ffha_pkg::S_DECODE: begin
            status_in    = ffha_pkg::StsOk;
            payload_in   = '0;
            count_in     = '0;
            steps_in     = '0;
            cur_in       = head_ptr;
            prev_in      = 32'd0;
            prev_head_in = 1'b1;
            state_in     = ffha_pkg::S_DONE;
            case (req_ff.req_type)
               ffha_pkg::ReqAlloc: begin
                  if (req_ff.req_size == '0 || head_ptr >= EndMark) begin
                     status_in = ffha_pkg::StsNoFit;
                  end else begin
                     need_in  = need_calc;
                     state_in = ffha_pkg::S_AL_CHK;
                  end
               end
               ffha_pkg::ReqFree: begin
                  if (req_ff.block_addr == '0) begin
                     status_in = ffha_pkg::StsOk;
                  end else if (req_ff.block_addr[2:0] != 3'd0
                               || req_ff.block_addr < 15'd8
                               || 32'(req_ff.block_addr) >= EndMark) begin
                     status_in = ffha_pkg::StsNotAlloc;
                  end else begin
                     blk_in   = 32'(req_ff.block_addr) - ffha_pkg::HdrBytes;
                     state_in = ffha_pkg::S_FR_RH;
                  end
               end
               ffha_pkg::ReqCount: begin
                  if (req_ff.req_size != '0) begin
                     state_in = ffha_pkg::S_CN_CHK;
                  end
               end
               default: begin
                  state_in = ffha_pkg::S_DONE;
               end
            endcase
         end

         ffha_pkg::S_AL_CHK: begin
            if (cur_ff < EndMark && steps_ff < MaxSteps) begin
               state_in = ffha_pkg::S_AL_RD0;
            end else begin
               status_in = ffha_pkg::StsNoFit;
               state_in  = ffha_pkg::S_DONE;
            end
         end
         ffha_pkg::S_AL_RD0: begin
            state_in = ffha_pkg::S_AL_D0;
         end
         ffha_pkg::S_AL_D0: begin
            csz_in   = rdata;
            steps_in = steps_ff + StepW'(1);
            state_in = ffha_pkg::S_AL_RD1;
         end
         ffha_pkg::S_AL_RD1: begin
            acc_k    = 1'b1;
            state_in = ffha_pkg::S_AL_D1;
         end
         ffha_pkg::S_AL_D1: begin
            link_in = rdata;
            if (csz_ff > need_ff) begin
               state_in = ffha_pkg::S_AL_WN0;
            end else if (csz_ff == need_ff) begin
               state_in = ffha_pkg::S_AL_LINK;
            end else begin
               prev_in      = cur_ff;
               prev_head_in = 1'b0;
               cur_in       = rdata;
               state_in     = ffha_pkg::S_AL_CHK;
            end
         end
         ffha_pkg::S_AL_WN0: begin
            acc_off  = cur_ff + need_ff;
            acc_we   = 1'b1;
            acc_wd   = csz_ff - need_ff;
            state_in = ffha_pkg::S_AL_WN1;
         end
         ffha_pkg::S_AL_WN1: begin
            acc_off  = cur_ff + need_ff;
            acc_k    = 1'b1;
            acc_we   = 1'b1;
            acc_wd   = link_ff;
            link_in  = cur_ff + need_ff;
            state_in = ffha_pkg::S_AL_LINK;
         end
         ffha_pkg::S_AL_LINK: begin
            if (prev_head_ff) begin
               head_in = clamp_sh[HeadW-1:0];
            end else begin
               acc_off = prev_ff;
               acc_k   = 1'b1;
               acc_we  = 1'b1;
               acc_wd  = link_ff;
            end
            state_in = ffha_pkg::S_AL_FIN;
         end
         ffha_pkg::S_AL_FIN: begin
            if (steps_ff >= MaxSteps) begin
               status_in = ffha_pkg::StsNoFit;
               state_in  = ffha_pkg::S_DONE;
            end else begin
               state_in = ffha_pkg::S_AL_WC0;
            end
         end
         ffha_pkg::S_AL_WC0: begin
            acc_we   = 1'b1;
            acc_wd   = need_ff | ffha_pkg::AllocBit;
            state_in = ffha_pkg::S_AL_WC1;
         end
         ffha_pkg::S_AL_WC1: begin
            acc_k      = 1'b1;
            acc_we     = 1'b1;
            acc_wd     = tag_ff;
            payload_in = 15'(cur_ff + ffha_pkg::HdrBytes);
            state_in   = ffha_pkg::S_DONE;
         end

         ffha_pkg::S_FR_RH: begin
            acc_off  = blk_ff;
            state_in = ffha_pkg::S_FR_DH;
         end
         ffha_pkg::S_FR_DH: begin
            csz_in = rdata;
            if (!rdata[31]) begin
               status_in = ffha_pkg::StsNotAlloc;
               state_in  = ffha_pkg::S_DONE;
            end else begin
               state_in = ffha_pkg::S_FR_RT;
            end
         end
         ffha_pkg::S_FR_RT: begin
            acc_off  = blk_ff;
            acc_k    = 1'b1;
            state_in = ffha_pkg::S_FR_DT;
         end
         ffha_pkg::S_FR_DT: begin
            if (rdata != tag_ff) begin
               status_in = ffha_pkg::StsWrongOwner;
               state_in  = ffha_pkg::S_DONE;
            end else begin
               need_in  = csz_ff & ffha_pkg::SizeMask;
               state_in = ffha_pkg::S_FR_WS;
            end
         end
         ffha_pkg::S_FR_WS: begin
            acc_off      = blk_ff;
            acc_we       = 1'b1;
            acc_wd       = need_ff;
            cur_in       = head_ptr;
            prev_in      = 32'd0;
            prev_head_in = 1'b1;
            steps_in     = '0;
            state_in     = ffha_pkg::S_FR_WALK;
         end
         ffha_pkg::S_FR_WALK: begin
            if (cur_ff < EndMark && cur_ff < blk_ff + need_ff && steps_ff < MaxSteps) begin
               state_in = ffha_pkg::S_FR_RW;
            end else begin
               if (cur_ff > EndMark) begin
                  cur_in = EndMark;
               end
               state_in = ffha_pkg::S_FR_RL;
            end
         end
         ffha_pkg::S_FR_RW: begin
            acc_k        = 1'b1;
            prev_in      = cur_ff;
            prev_head_in = 1'b0;
            state_in     = ffha_pkg::S_FR_DW;
         end
         ffha_pkg::S_FR_DW: begin
            cur_in   = rdata;
            steps_in = steps_ff + StepW'(1);
            state_in = ffha_pkg::S_FR_WALK;
         end
         ffha_pkg::S_FR_RL: begin
            acc_off  = prev_ff;
            state_in = ffha_pkg::S_FR_DL;
         end
         ffha_pkg::S_FR_DL: begin
            csz_in   = rdata;
            state_in = ffha_pkg::S_FR_RR;
         end
         ffha_pkg::S_FR_RR: begin
            state_in = ffha_pkg::S_FR_DR;
         end
         ffha_pkg::S_FR_DR: begin
            rsz_in    = rdata;
            prev_t_in = !prev_head_ff && (prev_ff + csz_ff == blk_ff);
            next_t_in = (cur_ff < EndMark) && (blk_ff + need_ff == cur_ff);
            if (!prev_head_ff && (prev_ff + csz_ff == blk_ff)) begin
               state_in = ffha_pkg::S_FR_WL0;
            end else if ((cur_ff < EndMark) && (blk_ff + need_ff == cur_ff)) begin
               state_in = ffha_pkg::S_FR_WB0;
            end else begin
               link_in  = cur_ff;
               state_in = ffha_pkg::S_FR_WB1;
            end
         end
         ffha_pkg::S_FR_WL0: begin
            acc_off  = prev_ff;
            acc_we   = 1'b1;
            acc_wd   = csz_ff + need_ff + (next_t_ff ? rsz_ff : 32'd0);
            state_in = next_t_ff ? ffha_pkg::S_FR_RR1 : ffha_pkg::S_DONE;
         end
         ffha_pkg::S_FR_WB0: begin
            acc_off  = blk_ff;
            acc_we   = 1'b1;
            acc_wd   = need_ff + rsz_ff;
            state_in = ffha_pkg::S_FR_RR1;
         end
         ffha_pkg::S_FR_RR1: begin
            acc_k    = 1'b1;
            state_in = ffha_pkg::S_FR_DR1;
         end
         ffha_pkg::S_FR_DR1: begin
            link_in  = rdata;
            state_in = prev_t_ff ? ffha_pkg::S_FR_WL1 : ffha_pkg::S_FR_WB1;
         end
         ffha_pkg::S_FR_WL1: begin
            acc_off  = prev_ff;
            acc_k    = 1'b1;
            acc_we   = 1'b1;
            acc_wd   = link_ff;
            state_in = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_FR_WB1: begin
            acc_off  = blk_ff;
            acc_k    = 1'b1;
            acc_we   = 1'b1;
            acc_wd   = link_ff;
            state_in = ffha_pkg::S_FR_LINK;
         end
         ffha_pkg::S_FR_LINK: begin
            clamp_src = blk_ff;
            if (prev_head_ff) begin
               head_in = clamp_sh[HeadW-1:0];
            end else begin
               acc_off = prev_ff;
               acc_k   = 1'b1;
               acc_we  = 1'b1;
               acc_wd  = blk_ff;
            end
            state_in = ffha_pkg::S_DONE;
         end

         ffha_pkg::S_CN_CHK: begin
            if (cur_ff < EndMark && steps_ff < MaxSteps) begin
               state_in = ffha_pkg::S_CN_RD0;
            end else begin
               state_in = ffha_pkg::S_DONE;
            end
         end
         ffha_pkg::S_CN_RD0: begin
            state_in = ffha_pkg::S_CN_D0;
         end
         ffha_pkg::S_CN_D0: begin
            if (rdata < size32) begin
               count_in = count_ff + 13'd1;
            end
            state_in = ffha_pkg::S_CN_RD1;
         end
         ffha_pkg::S_CN_RD1: begin
            acc_k    = 1'b1;
            state_in = ffha_pkg::S_CN_D1;
         end
         ffha_pkg::S_CN_D1: begin
            cur_in   = rdata;
            steps_in = steps_ff + StepW'(1);
            state_in = ffha_pkg::S_CN_CHK;
         end

         ffha_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.status       = status_ff;
               rsp_word_in.payload_addr = payload_ff;
               rsp_word_in.small_count  = count_ff;
               state_in                 = ffha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_CLEAR;
         head_ff      <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      req_ff       <= req_in;
      tag_ff       <= tag_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_head_ff <= prev_head_in;
      blk_ff       <= blk_in;
      need_ff      <= need_in;
      csz_ff       <= csz_in;
      rsz_ff       <= rsz_in;
      link_ff      <= link_in;
      steps_ff     <= steps_in;
      count_ff     <= count_in;
      status_ff    <= status_in;
      payload_ff   <= payload_in;
      prev_t_ff    <= prev_t_in;
      next_t_ff    <= next_t_in;
      rd_ok_ff     <= acc_ok;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign walk_quiet = state_ff == ffha_pkg::S_IDLE || state_ff == ffha_pkg::S_CLEAR
                       || state_ff == ffha_pkg::S_DECODE;
   assign rsp_load   = state_ff == ffha_pkg::S_DONE && (!rsp_valid_ff || rsp_ready);

   `FFHA_ASSERT_ALWAYS(a_head_in_range, head_ff <= HeadMax, "free list head past end of heap")
   `FFHA_ASSERT_ALWAYS(a_steps_bounded, steps_ff <= MaxSteps || walk_quiet, "walk past step bound")
   `FFHA_ASSERT_ALWAYS(a_no_rsp_in_clear, state_ff != ffha_pkg::S_CLEAR || !rsp_valid_ff, "rsp in clear")
   `FFHA_ASSERT_NEXT(a_accept_decodes, req_valid && req_ready, state_ff == ffha_pkg::S_DECODE, "no decode")
   `FFHA_ASSERT_NEXT(a_done_delivers, rsp_load, rsp_valid_ff && state_ff == ffha_pkg::S_IDLE, "no rsp")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the first-fit heap allocator core.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned HeapBytes = ffha_pkg::DefHeapBytes;
   localparam int unsigned HeapWords = HeapBytes / 4;
   localparam logic [31:0] EndMark   = 32'(HeapBytes);
   localparam int unsigned MaxWalk   = HeapBytes / 8 + 2;
   localparam int unsigned CycleLimit = 1500000;
   localparam logic [1:0] ReqUnused = 2'd3;

   typedef struct {
      logic [14:0] addr;
      logic [7:0]  owner;
      logic        stk;
   } live_block_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ffha_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ffha_pkg::rsp_word_type rsp_word;

   logic [31:0] heap_words [0:HeapWords-1];
   logic [31:0] free_head;
   ffha_pkg::rsp_word_type pending_rsps [$];
   live_block_type live_blocks [$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned burst_left = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned allocs_ok = 0;
   int unsigned frees_ok = 0;

   first_fit_heap_allocator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] hdr_read(logic [31:0] off, int unsigned k);
      logic [31:0] idx;
      idx = (off >> 2) + k;
      if (off >= EndMark || idx >= HeapWords) return 32'd0;
      return heap_words[idx];
   endfunction

   function automatic void hdr_write(logic [31:0] off, int unsigned k, logic [31:0] v);
      logic [31:0] idx;
      idx = (off >> 2) + k;
      if (off >= EndMark || idx >= HeapWords) return;
      heap_words[idx] = v;
   endfunction

   function automatic void relink(bit at_head, logic [31:0] node, logic [31:0] target);
      if (at_head) begin
         if (target > EndMark) target = EndMark;
         free_head = target >> 2;
      end else begin
         hdr_write(node, 1, target);
      end
   endfunction

   function automatic void heap_clear();
      for (int i = 0; i < HeapWords; i++) heap_words[i] = 32'd0;
      heap_words[0] = 32'(HeapBytes);
      heap_words[1] = EndMark;
      free_head = 32'd0;
   endfunction

   function automatic logic [1:0] take_block(logic [31:0] size, logic [31:0] tag,
                                             output logic [14:0] payload);
      logic [31:0] need, cur, prv, csz, nn;
      int unsigned steps;
      bit prv_head;
      payload = '0;
      prv = 0;
      steps = 0;
      prv_head = 1'b1;
      if (size == 0 || free_head * 4 >= EndMark) return ffha_pkg::StsNoFit;
      need = (size > 8) ? ((size + 7) & ~32'd7) : 32'd8;
      need += ffha_pkg::HdrBytes;
      cur = free_head * 4;
      while (cur < EndMark && steps < MaxWalk) begin
         csz = hdr_read(cur, 0);
         steps++;
         if (csz > need) begin
            nn = cur + need;
            hdr_write(nn, 0, csz - need);
            hdr_write(nn, 1, hdr_read(cur, 1));
            relink(prv_head, prv, nn);
            break;
         end else if (csz == need) begin
            relink(prv_head, prv, hdr_read(cur, 1));
            break;
         end
         prv = cur;
         prv_head = 1'b0;
         cur = hdr_read(cur, 1);
      end
      if (cur >= EndMark || steps >= MaxWalk) return ffha_pkg::StsNoFit;
      hdr_write(cur, 0, need | ffha_pkg::AllocBit);
      hdr_write(cur, 1, tag);
      payload = cur[14:0] + 15'd8;
      return ffha_pkg::StsOk;
   endfunction

   function automatic logic [1:0] free_block(logic [31:0] addr, logic [31:0] tag);
      logic [31:0] blk, h, s, left, right;
      int unsigned steps;
      bit left_head, prev_t, next_t;
      left = 0;
      steps = 0;
      left_head = 1'b1;
      if (addr == 0) return ffha_pkg::StsOk;
      if ((addr & 7) != 0 || addr < ffha_pkg::HdrBytes || addr >= EndMark) begin
         return ffha_pkg::StsNotAlloc;
      end
      blk = addr - ffha_pkg::HdrBytes;
      h = hdr_read(blk, 0);
      if ((h & ffha_pkg::AllocBit) == 0) return ffha_pkg::StsNotAlloc;
      if (hdr_read(blk, 1) != tag) return ffha_pkg::StsWrongOwner;
      s = h & ffha_pkg::SizeMask;
      hdr_write(blk, 0, s);
      right = free_head * 4;
      while (right < EndMark && right < blk + s && steps < MaxWalk) begin
         left = right;
         left_head = 1'b0;
         right = hdr_read(right, 1);
         steps++;
      end
      if (right > EndMark) right = EndMark;
      prev_t = !left_head && (left + hdr_read(left, 0) == blk);
      next_t = (right < EndMark) && (blk + s == right);
      if (prev_t && next_t) begin
         hdr_write(left, 0, hdr_read(left, 0) + s + hdr_read(right, 0));
         hdr_write(left, 1, hdr_read(right, 1));
      end else if (prev_t) begin
         hdr_write(left, 0, hdr_read(left, 0) + s);
      end else if (next_t) begin
         hdr_write(blk, 0, s + hdr_read(right, 0));
         hdr_write(blk, 1, hdr_read(right, 1));
         relink(left_head, left, blk);
      end else begin
         hdr_write(blk, 1, right);
         relink(left_head, left, blk);
      end
      return ffha_pkg::StsOk;
   endfunction

   function automatic logic [12:0] count_smaller(logic [31:0] size);
      logic [31:0] cur, n;
      int unsigned steps;
      n = 0;
      steps = 0;
      if (size == 0) return '0;
      cur = free_head * 4;
      while (cur < EndMark && steps < MaxWalk) begin
         if (hdr_read(cur, 0) < size) n++;
         cur = hdr_read(cur, 1);
         steps++;
      end
      return n[12:0];
   endfunction

   function automatic ffha_pkg::rsp_word_type heap_apply(ffha_pkg::req_word_type w);
      ffha_pkg::rsp_word_type r;
      logic [31:0] tag;
      logic [14:0] pay;
      r = '0;
      tag = w.stack_owner ? ffha_pkg::StackTag : ({24'd0, w.owner_id} & ffha_pkg::OwnerMask);
      case (w.req_type)
         ffha_pkg::ReqAlloc: begin
            r.status = take_block({16'd0, w.req_size}, tag, pay);
            r.payload_addr = pay;
         end
         ffha_pkg::ReqFree: r.status = free_block({17'd0, w.block_addr}, tag);
         ffha_pkg::ReqCount: r.small_count = count_smaller({16'd0, w.req_size});
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic send_word(input ffha_pkg::req_word_type w,
                            output ffha_pkg::rsp_word_type r);
      int unsigned gap;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      r = heap_apply(w);
      pending_rsps.push_back(r);
      words_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic ffha_pkg::req_word_type make_word(logic [1:0] t, logic [15:0] size,
                                                        logic [14:0] addr, logic [7:0] owner,
                                                        logic stk);
      ffha_pkg::req_word_type w;
      w.req_type = t;
      w.req_size = size;
      w.block_addr = addr;
      w.owner_id = owner;
      w.stack_owner = stk;
      return w;
   endfunction

   task automatic alloc_and_track(logic [15:0] size, logic [7:0] owner, logic stk);
      ffha_pkg::rsp_word_type r;
      live_block_type b;
      send_word(make_word(ffha_pkg::ReqAlloc, size, 15'($urandom), owner, stk), r);
      if (r.status == ffha_pkg::StsOk) begin
         b.addr = r.payload_addr;
         b.owner = owner;
         b.stk = stk;
         live_blocks.push_back(b);
         allocs_ok++;
      end
   endtask

   task automatic free_tracked(int unsigned idx);
      ffha_pkg::rsp_word_type r;
      live_block_type b;
      b = live_blocks[idx];
      send_word(make_word(ffha_pkg::ReqFree, 16'($urandom), b.addr, b.owner, b.stk), r);
      if (r.status == ffha_pkg::StsOk) begin
         live_blocks.delete(idx);
         frees_ok++;
      end
   endtask

   task automatic test_alloc_edges();
      ffha_pkg::rsp_word_type r;
      alloc_and_track(16'd0, 8'd1, 1'b0);
      alloc_and_track(16'd1, 8'd0, 1'b0);
      alloc_and_track(16'd8, 8'hFF, 1'b0);
      alloc_and_track(16'd9, 8'h5A, 1'b1);
      alloc_and_track(16'hFFFF, 8'hA5, 1'b0);
      alloc_and_track(16'd32768, 8'd3, 1'b0);
      send_word(make_word(ReqUnused, 16'hFFFF, 15'h7FFF, 8'hFF, 1'b1), r);
   endtask

   task automatic test_free_edges();
      ffha_pkg::rsp_word_type r;
      live_block_type b;
      b = live_blocks[0];
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, 15'd0, 8'd0, 1'b0), r);
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, 15'h7FFF, 8'd0, 1'b0), r);
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, 15'd4, 8'd0, 1'b0), r);
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, 15'h7FF8, 8'd0, 1'b0), r);
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, b.addr, b.owner ^ 8'h01, b.stk), r);
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, b.addr, b.owner, 1'b1), r);
      while (live_blocks.size() > 0) free_tracked(live_blocks.size() - 1);
      send_word(make_word(ffha_pkg::ReqFree, 16'd0, b.addr, b.owner, b.stk), r);
   endtask

   task automatic test_full_heap();
      ffha_pkg::rsp_word_type r;
      alloc_and_track(16'd32760, 8'h77, 1'b0);
      alloc_and_track(16'd8, 8'h77, 1'b0);
      send_word(make_word(ffha_pkg::ReqCount, 16'd1, 15'd0, 8'd0, 1'b0), r);
      free_tracked(0);
      send_word(make_word(ffha_pkg::ReqCount, 16'd0, 15'd0, 8'd0, 1'b0), r);
      send_word(make_word(ffha_pkg::ReqCount, 16'hFFFF, 15'd0, 8'd0, 1'b0), r);
   endtask

   task automatic test_random_mix(int unsigned n_words);
      ffha_pkg::rsp_word_type r;
      int unsigned pick;
      logic [15:0] size;
      live_block_type b;
      for (int i = 0; i < n_words; i++) begin
         pick = $urandom_range(0, 99);
         if (live_blocks.size() > 50 && pick < 45) pick += 45;
         if (pick < 45) begin
            size = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                   : 16'($urandom_range(0, 300));
            alloc_and_track(size, 8'($urandom), $urandom_range(0, 7) == 0);
         end else if (pick < 80 && live_blocks.size() > 0) begin
            free_tracked($urandom_range(0, live_blocks.size() - 1));
         end else if (pick < 88 && live_blocks.size() > 0) begin
            b = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_word(make_word(ffha_pkg::ReqFree, 16'($urandom),
                                b.addr ^ (15'd1 << $urandom_range(0, 14)),
                                b.owner ^ 8'($urandom), 1'($urandom)), r);
         end else if (pick < 95) begin
            send_word(make_word(ffha_pkg::ReqCount, 16'($urandom_range(0, 600)),
                                15'($urandom), 8'($urandom), 1'($urandom)), r);
         end else if (pick < 98) begin
            send_word(make_word(ffha_pkg::ReqFree, 16'($urandom), 15'($urandom),
                                8'($urandom), 1'($urandom)), r);
         end else begin
            send_word(make_word(ReqUnused, 16'($urandom), 15'($urandom), 8'($urandom),
                                1'($urandom)), r);
         end
      end
   endtask

   always @(posedge clock) begin
      int unsigned phase;
      phase = (cycles / 97) % 3;
      if (phase == 0) rsp_ready <= 1'b1;
      else if (phase == 1) rsp_ready <= 1'($urandom_range(0, 1));
      else rsp_ready <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      ffha_pkg::rsp_word_type e;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("first_fit_heap_allocator_core test failed");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (pending_rsps.size() == 0) begin
            $display("%t unexpected word: actual %p", $time, rsp_word);
            errors++;
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_word.status !== e.status) begin
               $display("%t status: expected %0d actual %0d", $time, e.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.payload_addr !== e.payload_addr) begin
               $display("%t payload_addr: expected %0h actual %0h", $time,
                        e.payload_addr, rsp_word.payload_addr);
               errors++;
            end
            if (rsp_word.small_count !== e.small_count) begin
               $display("%t small_count: expected %0d actual %0d", $time,
                        e.small_count, rsp_word.small_count);
               errors++;
            end
         end
      end
   end

   initial begin
      heap_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_alloc_edges();
      test_free_edges();
      test_full_heap();
      test_random_mix(740);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Sent %0d words and checked %0d responses.", words_sent, words_checked);
      $display("Allocations granted: %0d, blocks released: %0d.", allocs_ok, frees_ok);
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("first_fit_heap_allocator_core test passed");
      end else begin
         $display("first_fit_heap_allocator_core test failed");
      end
      $finish;
   end

endmodule
